@@ rtl/gda_pkg.sv @@
package gda_pkg;

    // field widths
    localparam int DAY_BITS   = 5;
    localparam int MONTH_BITS = 4;
    localparam int YEAR_BITS  = 14;
    localparam int ADD_BITS   = 16;
    localparam int STAT_BITS  = 2;

    // running day count holds day plus the whole addend
    localparam int DSUM_BITS = ADD_BITS + 1;

    // remainder of the year by one hundred
    localparam int REM_BITS = 7;

    // reciprocal of one hundred, exact for every year of YEAR_BITS bits
    localparam int RECIP_SHIFT = YEAR_BITS + 7;
    localparam int RECIP_BITS  = YEAR_BITS + 1;
    localparam int PROD_BITS   = YEAR_BITS + RECIP_BITS;
    localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;

    localparam logic [RECIP_BITS-1:0] RECIP_CENTURY =
        RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100);

    localparam logic [REM_BITS-1:0]   CENTURY_LAST = REM_BITS'(99);
    localparam logic [YEAR_BITS-1:0]  CENTURY      = YEAR_BITS'(100);
    localparam logic [MONTH_BITS-1:0] MONTH_JAN    = MONTH_BITS'(1);
    localparam logic [MONTH_BITS-1:0] MONTH_FEB    = MONTH_BITS'(2);
    localparam logic [MONTH_BITS-1:0] MONTH_DEC    = MONTH_BITS'(12);
    localparam logic [DAY_BITS-1:0]   DAY_LAST     = DAY_BITS'(31);
    localparam logic [YEAR_BITS-1:0]  YEAR_MAX     = '1;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_BAD_MONTH = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_BAD_DAY   = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_BAD_YEAR  = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic check;
        logic step;
        logic emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } t_sts;

    // length of a month given the leap flag of its year
    function automatic logic [DAY_BITS-1:0] month_len(
        input logic [MONTH_BITS-1:0] m,
        input logic                  leap
    );
        logic [DAY_BITS-1:0] len;
        len = DAY_BITS'(31);
        case (m)
            4'd2:    len = leap ? DAY_BITS'(29) : DAY_BITS'(28);
            4'd4:    len = DAY_BITS'(30);
            4'd6:    len = DAY_BITS'(30);
            4'd9:    len = DAY_BITS'(30);
            4'd11:   len = DAY_BITS'(30);
            default: len = DAY_BITS'(31);
        endcase
        return len;
    endfunction

endpackage

@@ rtl/gda_if.sv @@
// input channel: start date and day count
interface gda_in_if;
    import gda_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
    logic [ADD_BITS-1:0]   days_to_add;

    modport source (output valid, day, month, year, days_to_add, input ready);
    modport sink   (input valid, day, month, year, days_to_add, output ready);
endinterface

// output channel: resulting date and flags
interface gda_out_if;
    import gda_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DAY_BITS-1:0]   out_day;
    logic [MONTH_BITS-1:0] out_month;
    logic [YEAR_BITS-1:0]  out_year;
    logic                  is_leap;
    logic [STAT_BITS-1:0]  status;
    logic                  overflow;

    modport source (output valid, out_day, out_month, out_year, is_leap, status, overflow,
                    input ready);
    modport sink   (input valid, out_day, out_month, out_year, is_leap, status, overflow,
                    output ready);
endinterface

@@ rtl/gda_ctrl.sv @@
module gda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gda_pkg::t_sts i_sts,
    output gda_pkg::t_cmd o_cmd
);
    import gda_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state        = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/gda_dpath.sv @@
module gda_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gda_in_if.sink        i_in,
    gda_out_if.source     o_res,
    input  gda_pkg::t_cmd i_cmd,
    output gda_pkg::t_sts o_sts
);
    import gda_pkg::*;

    logic [DSUM_BITS-1:0]  r_d;
    logic [MONTH_BITS-1:0] r_m;
    logic [YEAR_BITS-1:0]  r_y;
    logic [ADD_BITS-1:0]   r_add;
    logic [REM_BITS-1:0]   r_rem;
    logic [1:0]            r_q4;
    logic [STAT_BITS-1:0]  r_status;
    logic                  r_ovf;

    logic                  r_o_valid;
    logic [DAY_BITS-1:0]   r_o_day;
    logic [MONTH_BITS-1:0] r_o_month;
    logic [YEAR_BITS-1:0]  r_o_year;
    logic                  r_o_leap;
    logic [STAT_BITS-1:0]  r_o_status;
    logic                  r_o_ovf;

    logic                  leap;
    logic [DAY_BITS-1:0]   len;
    logic [PROD_BITS-1:0]  y_prod;
    logic [QUOT_BITS-1:0]  y_quot;
    logic [REM_BITS-1:0]   y_rem;
    logic [STAT_BITS-1:0]  chk;

    // leap rule from year mod 4, year mod 100 and century mod 4
    assign leap = (r_y[1:0] == 2'd0) && ((r_rem != '0) || (r_q4 == 2'd0));
    assign len  = month_len(r_m, leap);

    // year split by one hundred through a reciprocal multiply
    assign y_prod = PROD_BITS'(r_y) * PROD_BITS'(RECIP_CENTURY);
    assign y_quot = y_prod[PROD_BITS-1:RECIP_SHIFT];
    assign y_rem  = REM_BITS'(r_y - YEAR_BITS'(y_quot) * CENTURY);

    // date check in month, day, year order
    always_comb begin
        if ((r_m < MONTH_JAN) || (r_m > MONTH_DEC)) begin
            chk = ST_BAD_MONTH;
        end else if ((r_d == '0) || (r_d > DSUM_BITS'(len))) begin
            chk = ST_BAD_DAY;
        end else if (r_y == '0) begin
            chk = ST_BAD_YEAR;
        end else begin
            chk = ST_OK;
        end
    end

    // an invalid date leaves the walk at once
    assign o_sts.walk_done = (r_status != ST_OK) || (r_d <= DSUM_BITS'(len)) || r_ovf;
    assign o_sts.out_free  = !r_o_valid || o_res.ready;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d      <= DSUM_BITS'(i_in.day);
            r_m      <= i_in.month;
            r_y      <= i_in.year;
            r_add    <= i_in.days_to_add;
            r_rem    <= '0;
            r_q4     <= '0;
            r_status <= ST_OK;
            r_ovf    <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_rem <= y_rem;
            r_q4  <= y_quot[1:0];
        end else if (i_cmd.check) begin
            r_status <= chk;
            if (chk == ST_OK) begin
                r_d <= r_d + DSUM_BITS'(r_add);
            end
        end else if (i_cmd.step) begin
            if (r_m == MONTH_DEC) begin
                if (r_y == YEAR_MAX) begin
                    // saturate at the last day of the maximum year
                    r_ovf <= 1'b1;
                    r_d   <= DSUM_BITS'(DAY_LAST);
                end else begin
                    r_d <= r_d - DSUM_BITS'(len);
                    r_m <= MONTH_JAN;
                    r_y <= r_y + 1'b1;
                    if (r_rem == CENTURY_LAST) begin
                        r_rem <= '0;
                        r_q4  <= r_q4 + 1'b1;
                    end else begin
                        r_rem <= r_rem + 1'b1;
                    end
                end
            end else begin
                r_d <= r_d - DSUM_BITS'(len);
                r_m <= r_m + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_day    <= r_d[DAY_BITS-1:0];
            r_o_month  <= r_m;
            r_o_year   <= r_y;
            r_o_leap   <= leap;
            r_o_status <= r_status;
            r_o_ovf    <= r_ovf;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.out_day   = r_o_day;
    assign o_res.out_month = r_o_month;
    assign o_res.out_year  = r_o_year;
    assign o_res.is_leap   = r_o_leap;
    assign o_res.status    = r_o_status;
    assign o_res.overflow  = r_o_ovf;

endmodule

@@ rtl/gregorian_date_add_days.sv @@
// Gregorian date plus day count.
// Input channel i_in carries day, month, year and days_to_add; one beat is
// taken whenever the block is idle. Output channel o_res carries the new date,
// the leap flag of its year, a status code (ok, bad month, bad day, bad year)
// and an overflow flag when the year saturates at its maximum.
// Each input beat gives exactly one output beat, in order.
// Steps from the input beat: split the year by one hundred, check the date,
// walk one month per step until the day fits its month, then load the result
// into the output register once it is free. An invalid date skips the walk.
// The next input beat is taken in the cycle after the result is loaded into
// the output register, so the block takes no new date until it is through
// with the last one, and the month walk sets the throughput.
// A result left waiting in the output register does not block the next beat;
// a second finished result waits in the datapath until the first is taken.
// Synchronous reset clears the controller and the output valid flag.
module gregorian_date_add_days (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gda_in_if.sink    i_in,
    gda_out_if.source o_res
);
    import gda_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gda_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_res   (o_res),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
